// ===== rtl/apra_pkg.sv =====
// Shared types for the address pool range allocator: operation and register codes,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
package apra_pkg;

    // Operation carried by an input item.
    typedef enum logic [1:0] {
        OP_OFFER   = 2'd0,
        OP_COMMIT  = 2'd1,
        OP_RECYCLE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_POOL_BASE    = 2'd0,
        CFG_LEASE_LENGTH = 2'd1,
        CFG_RANGE_LENGTH = 2'd2,
        CFG_RANGE_COUNT  = 2'd3
    } cfg_reg_t;

    // Source of the used-bit read address.
    typedef enum logic [1:0] {
        RD_CURSOR      = 2'd0,
        RD_CURSOR_NEXT = 2'd1,
        RD_OFFSET      = 2'd2
    } rd_sel_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_NX_LOAD,
        ST_NX_MOD,
        ST_NX_CHK,
        ST_CLEAR,
        ST_BASE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FOUND,
        ST_CM_BASE,
        ST_CM_OFF,
        ST_CM_RD,
        ST_CM_CHK,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    take_in;
        logic    res_clr;
        logic    sweep_rst;
        logic    sweep_wr;
        logic    sweep_full;
        logic    tgt_ridx;
        logic    nxt_load;
        logic    nxt_sub;
        logic    exp_rd_nxt;
        logic    exp_rd_cur;
        logic    adopt_nxt;
        logic    exp_clr;
        logic    exp_set;
        logic    base_ld;
        logic    bit_rd;
        rd_sel_t bit_rd_sel;
        logic    cur_inc;
        logic    cand_ld;
        logic    res_off_ld;
        logic    off_ld;
        logic    bit_set;
        logic    res_acc_set;
        logic    out_ld;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic cursor_full;
        logic scan_last;
        logic bit_free;
        logic nxt_ge;
        logic exp_zero;
        logic exp_expired;
        logic ridx_ok;
        logic in_range;
        logic cand_zero;
        logic sweep_last_full;
        logic sweep_last_row;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/apra_ctrl.sv =====
// Controller of the address pool range allocator: sequences the clearing pass,
// offer, commit and recycle operations. Depends on apra_pkg.
module apra_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  apra_pkg::sts_t  sts,
    output apra_pkg::cmd_t  cmd
);

    apra_pkg::state_t state_reg;
    apra_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= apra_pkg::ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            apra_pkg::ST_INIT: begin
                // Clear every used bit once after reset.
                cmd.sweep_wr   = 1'b1;
                cmd.sweep_full = 1'b1;
                if (sts.sweep_last_full) begin
                    state_next = apra_pkg::ST_IDLE;
                end
            end
            apra_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.take_in = 1'b1;
                    state_next  = apra_pkg::ST_DISPATCH;
                end
            end
            apra_pkg::ST_DISPATCH: begin
                cmd.res_clr = 1'b1;
                unique case (sts.op)
                    apra_pkg::OP_OFFER: begin
                        if (sts.cursor_full) begin
                            state_next = apra_pkg::ST_NX_LOAD;
                        end else begin
                            state_next = apra_pkg::ST_BASE;
                        end
                    end
                    apra_pkg::OP_COMMIT: begin
                        state_next = apra_pkg::ST_CM_BASE;
                    end
                    apra_pkg::OP_RECYCLE: begin
                        if (sts.ridx_ok) begin
                            cmd.tgt_ridx  = 1'b1;
                            cmd.sweep_rst = 1'b1;
                            state_next    = apra_pkg::ST_CLEAR;
                        end else begin
                            state_next = apra_pkg::ST_DONE;
                        end
                    end
                    apra_pkg::OP_NONE: begin
                        state_next = apra_pkg::ST_DONE;
                    end
                endcase
            end
            apra_pkg::ST_NX_LOAD: begin
                cmd.nxt_load = 1'b1;
                state_next   = apra_pkg::ST_NX_MOD;
            end
            apra_pkg::ST_NX_MOD: begin
                // Reduce the next range index by repeated subtraction of the count.
                if (sts.nxt_ge) begin
                    cmd.nxt_sub = 1'b1;
                end else begin
                    cmd.exp_rd_nxt = 1'b1;
                    state_next     = apra_pkg::ST_NX_CHK;
                end
            end
            apra_pkg::ST_NX_CHK: begin
                if (sts.exp_expired) begin
                    cmd.adopt_nxt = 1'b1;
                    cmd.sweep_rst = 1'b1;
                    state_next    = apra_pkg::ST_CLEAR;
                end else if (sts.exp_zero) begin
                    cmd.adopt_nxt = 1'b1;
                    state_next    = apra_pkg::ST_BASE;
                end else begin
                    state_next = apra_pkg::ST_DONE;
                end
            end
            apra_pkg::ST_CLEAR: begin
                cmd.sweep_wr = 1'b1;
                cmd.exp_clr  = 1'b1;
                if (sts.sweep_last_row) begin
                    if (sts.op == apra_pkg::OP_OFFER) begin
                        state_next = apra_pkg::ST_BASE;
                    end else begin
                        state_next = apra_pkg::ST_DONE;
                    end
                end
            end
            apra_pkg::ST_BASE: begin
                cmd.base_ld    = 1'b1;
                cmd.exp_rd_cur = 1'b1;
                state_next     = apra_pkg::ST_SCAN_RD;
            end
            apra_pkg::ST_SCAN_RD: begin
                cmd.bit_rd     = 1'b1;
                cmd.bit_rd_sel = apra_pkg::RD_CURSOR;
                state_next     = apra_pkg::ST_SCAN_CHK;
            end
            apra_pkg::ST_SCAN_CHK: begin
                // One bit a cycle: check the bit read last cycle, read the following one.
                cmd.cur_inc = 1'b1;
                if (sts.bit_free) begin
                    cmd.cand_ld = 1'b1;
                    state_next  = apra_pkg::ST_FOUND;
                end else if (sts.scan_last) begin
                    state_next = apra_pkg::ST_DONE;
                end else begin
                    cmd.bit_rd     = 1'b1;
                    cmd.bit_rd_sel = apra_pkg::RD_CURSOR_NEXT;
                end
            end
            apra_pkg::ST_FOUND: begin
                cmd.res_off_ld = 1'b1;
                if (!sts.cand_zero && sts.exp_zero && sts.cursor_full) begin
                    cmd.exp_set = 1'b1;
                end
                state_next = apra_pkg::ST_DONE;
            end
            apra_pkg::ST_CM_BASE: begin
                cmd.base_ld = 1'b1;
                state_next  = apra_pkg::ST_CM_OFF;
            end
            apra_pkg::ST_CM_OFF: begin
                cmd.off_ld = 1'b1;
                state_next = apra_pkg::ST_CM_RD;
            end
            apra_pkg::ST_CM_RD: begin
                cmd.bit_rd     = 1'b1;
                cmd.bit_rd_sel = apra_pkg::RD_OFFSET;
                state_next     = apra_pkg::ST_CM_CHK;
            end
            apra_pkg::ST_CM_CHK: begin
                if (sts.in_range && sts.bit_free) begin
                    cmd.bit_set     = 1'b1;
                    cmd.res_acc_set = 1'b1;
                end
                state_next = apra_pkg::ST_DONE;
            end
            apra_pkg::ST_DONE: begin
                // Hand the result to the output register once it is free.
                if (sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = apra_pkg::ST_IDLE;
                end
            end
        endcase
    end

endmodule

// ===== rtl/apra_dp.sv =====
// Datapath of the address pool range allocator: configuration registers, used-bit
// memory, expiry memory, cursor and range registers and the output register.
// Depends on apra_pkg.
module apra_dp #(
    parameter int MAX_RANGE_LEN = 256,
    parameter int MAX_RANGES    = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_wr_data,
    input  logic [1:0]     s_operation,
    input  logic [31:0]    s_now_time,
    input  logic [31:0]    s_address,
    input  logic [2:0]     s_range_index,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_offered_address,
    output logic           m_accepted,
    input  apra_pkg::cmd_t cmd,
    output apra_pkg::sts_t sts
);

    localparam int DEPTH = MAX_RANGES * MAX_RANGE_LEN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW    = (MAX_RANGE_LEN > 1) ? $clog2(MAX_RANGE_LEN) : 1;
    localparam int CW    = $clog2(MAX_RANGE_LEN + 1);
    localparam int RW    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int NW    = $clog2(MAX_RANGES + 1);
    localparam int PW    = RW + CW;

    // Configuration registers.
    logic [31:0] pool_base_reg;
    logic [31:0] lease_length_reg;
    logic [8:0]  range_length_reg;
    logic [3:0]  range_count_reg;

    // Latched input item.
    apra_pkg::op_t op_reg;
    logic [31:0]   now_reg;
    logic [31:0]   addr_reg;
    logic [2:0]    ridx_reg;

    // Allocation state and working registers.
    logic [RW-1:0] cur_reg;
    logic [CW-1:0] cursor_reg;
    logic [RW-1:0] tgt_reg;
    logic [NW-1:0] nxt_reg;
    logic [AW-1:0] sw_reg;
    logic [31:0]   base_reg;
    logic [31:0]   cand_reg;
    logic [OW-1:0] off_reg;
    logic          in_range_reg;
    logic [31:0]   res_off_reg;
    logic          res_acc_reg;

    // Output register.
    logic          m_valid_reg;
    logic [31:0]   m_offered_address_reg;
    logic          m_accepted_reg;

    // Memories.
    logic          bits_mem [DEPTH];
    logic          bit_rdata_reg;
    logic [31:0]   exp_mem [MAX_RANGES];
    logic [31:0]   exp_rdata_reg;
    logic          exp_hit_reg;
    logic [MAX_RANGES-1:0] exp_vld_reg;

    logic [CW-1:0] len_eff;
    logic [NW-1:0] count_eff;
    logic [CW:0]   cursor_inc;
    logic [PW-1:0] base_prod;
    logic [31:0]   rel_addr;
    logic [31:0]   exp_val;
    logic [AW-1:0] row_cur;
    logic [AW-1:0] bit_raddr;
    logic [AW-1:0] bit_waddr;
    logic          bit_we;
    logic          bit_wdata;
    logic          exp_rd;
    logic [RW-1:0] exp_raddr;

    // Lengths in use, clamped to the storage.
    always_comb begin
        if (range_length_reg == 9'd0) begin
            len_eff = CW'(1);
        end else if (32'(range_length_reg) > 32'(MAX_RANGE_LEN)) begin
            len_eff = CW'(MAX_RANGE_LEN);
        end else begin
            len_eff = CW'(range_length_reg);
        end
        if (range_count_reg == 4'd0) begin
            count_eff = NW'(1);
        end else if (32'(range_count_reg) > 32'(MAX_RANGES)) begin
            count_eff = NW'(MAX_RANGES);
        end else begin
            count_eff = NW'(range_count_reg);
        end
    end

    assign cursor_inc = {1'b0, cursor_reg} + (CW + 1)'(1);
    assign base_prod  = PW'(cur_reg) * PW'(len_eff);
    assign rel_addr   = addr_reg - base_reg;
    assign exp_val    = exp_hit_reg ? exp_rdata_reg : 32'd0;
    assign row_cur    = AW'(cur_reg) * AW'(MAX_RANGE_LEN);

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_base_reg    <= 32'd0;
            lease_length_reg <= 32'd3600;
            range_length_reg <= 9'd256;
            range_count_reg  <= 4'd8;
        end else if (cfg_wr_en) begin
            unique case (apra_pkg::cfg_reg_t'(cfg_index))
                apra_pkg::CFG_POOL_BASE:    pool_base_reg    <= cfg_wr_data;
                apra_pkg::CFG_LEASE_LENGTH: lease_length_reg <= cfg_wr_data;
                apra_pkg::CFG_RANGE_LENGTH: range_length_reg <= cfg_wr_data[8:0];
                apra_pkg::CFG_RANGE_COUNT:  range_count_reg  <= cfg_wr_data[3:0];
            endcase
        end
    end

    // Input item capture.
    always_ff @(posedge aclk) begin
        if (cmd.take_in) begin
            op_reg   <= apra_pkg::op_t'(s_operation);
            now_reg  <= s_now_time;
            addr_reg <= s_address;
            ridx_reg <= s_range_index;
        end
    end

    // Current range, scan cursor and sweep counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= '0;
            cursor_reg <= '0;
            sw_reg     <= '0;
        end else begin
            if (cmd.adopt_nxt) begin
                cur_reg    <= RW'(nxt_reg);
                cursor_reg <= '0;
            end else if (cmd.cur_inc) begin
                cursor_reg <= CW'(cursor_inc);
            end
            if (cmd.sweep_rst) begin
                sw_reg <= '0;
            end else if (cmd.sweep_wr) begin
                sw_reg <= AW'(sw_reg + AW'(1));
            end
        end
    end

    // Working registers of one operation.
    always_ff @(posedge aclk) begin
        if (cmd.tgt_ridx) begin
            tgt_reg <= RW'(ridx_reg);
        end else if (cmd.adopt_nxt) begin
            tgt_reg <= RW'(nxt_reg);
        end
        if (cmd.nxt_load) begin
            nxt_reg <= NW'(cur_reg) + NW'(1);
        end else if (cmd.nxt_sub) begin
            nxt_reg <= nxt_reg - count_eff;
        end
        if (cmd.base_ld) begin
            base_reg <= pool_base_reg + 32'(base_prod);
        end
        if (cmd.cand_ld) begin
            cand_reg <= base_reg + 32'(cursor_reg);
        end
        if (cmd.off_ld) begin
            off_reg      <= OW'(rel_addr);
            in_range_reg <= rel_addr < 32'(len_eff);
        end
        if (cmd.res_clr) begin
            res_off_reg <= 32'd0;
            res_acc_reg <= 1'b0;
        end else begin
            if (cmd.res_off_ld) begin
                res_off_reg <= cand_reg;
            end
            if (cmd.res_acc_set) begin
                res_acc_reg <= 1'b1;
            end
        end
    end

    // Used-bit memory addressing.
    always_comb begin
        unique case (cmd.bit_rd_sel)
            apra_pkg::RD_CURSOR:      bit_raddr = row_cur + AW'(cursor_reg);
            apra_pkg::RD_CURSOR_NEXT: bit_raddr = row_cur + AW'(cursor_inc);
            apra_pkg::RD_OFFSET:      bit_raddr = row_cur + AW'(off_reg);
            default:                  bit_raddr = row_cur;
        endcase
        if (cmd.sweep_wr) begin
            bit_waddr = cmd.sweep_full ? sw_reg
                                       : AW'(tgt_reg) * AW'(MAX_RANGE_LEN) + sw_reg;
            bit_wdata = 1'b0;
        end else begin
            bit_waddr = row_cur + AW'(off_reg);
            bit_wdata = 1'b1;
        end
        bit_we = cmd.sweep_wr | cmd.bit_set;
    end

    // Used-bit memory.
    always_ff @(posedge aclk) begin
        if (bit_we) begin
            bits_mem[bit_waddr] <= bit_wdata;
        end
        if (cmd.bit_rd) begin
            bit_rdata_reg <= bits_mem[bit_raddr];
        end
    end

    assign exp_rd    = cmd.exp_rd_nxt | cmd.exp_rd_cur;
    assign exp_raddr = cmd.exp_rd_nxt ? RW'(nxt_reg) : cur_reg;

    // Expiry memory; an entry without its valid bit reads as zero.
    always_ff @(posedge aclk) begin
        if (cmd.exp_set) begin
            exp_mem[cur_reg] <= now_reg + lease_length_reg;
        end
        if (exp_rd) begin
            exp_rdata_reg <= exp_mem[exp_raddr];
            exp_hit_reg   <= exp_vld_reg[exp_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_vld_reg <= '0;
        end else begin
            if (cmd.exp_set) begin
                exp_vld_reg[cur_reg] <= 1'b1;
            end
            if (cmd.exp_clr) begin
                exp_vld_reg[tgt_reg] <= 1'b0;
            end
        end
    end

    // Output register: a result item waits here while the next item is taken in.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_ld) begin
            m_offered_address_reg <= res_off_reg;
            m_accepted_reg        <= res_acc_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_offered_address = m_offered_address_reg;
    assign m_accepted        = m_accepted_reg;

    // Status towards the controller.
    always_comb begin
        sts.op              = op_reg;
        sts.cursor_full     = cursor_reg >= len_eff;
        sts.scan_last       = cursor_inc >= {1'b0, len_eff};
        sts.bit_free        = !bit_rdata_reg;
        sts.nxt_ge          = nxt_reg >= count_eff;
        sts.exp_zero        = exp_val == 32'd0;
        sts.exp_expired     = (exp_val != 32'd0) && (exp_val <= now_reg);
        sts.ridx_ok         = 32'(ridx_reg) < 32'(count_eff);
        sts.in_range        = in_range_reg;
        sts.cand_zero       = cand_reg == 32'd0;
        sts.sweep_last_full = sw_reg == AW'(DEPTH - 1);
        sts.sweep_last_row  = sw_reg == AW'(MAX_RANGE_LEN - 1);
        sts.out_free        = !m_valid_reg || m_ready;
    end

endmodule

// ===== rtl/address_pool_range_allocator.sv =====
// Address pool range allocator, top level. One item is worked on at a time.
// A commit checks one used bit and sets it if free, a valid recycle clears one range, and an
// offer scans used bits from the cursor; an offer that moves to another range first reduces
// the range index by repeated subtraction and clears that range if its lease expired.
// The used-bit memory read port examines one bit per cycle and sets the offer rate.
// After reset a clearing pass over every used bit runs with s_ready low.
module address_pool_range_allocator #(
    parameter int MAX_RANGE_LEN = 256,
    parameter int MAX_RANGES    = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [31:0] s_now_time,
    input  logic [31:0] s_address,
    input  logic [2:0]  s_range_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_offered_address,
    output logic        m_accepted
);

    apra_pkg::cmd_t cmd;
    apra_pkg::sts_t sts;

    // Sequencer.
    apra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Storage and arithmetic.
    apra_dp #(
        .MAX_RANGE_LEN (MAX_RANGE_LEN),
        .MAX_RANGES    (MAX_RANGES)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_operation       (s_operation),
        .s_now_time        (s_now_time),
        .s_address         (s_address),
        .s_range_index     (s_range_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_offered_address (m_offered_address),
        .m_accepted        (m_accepted),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule

// ===== dv/address_pool_range_allocator_test.sv =====
// Self-checking testbench for address_pool_range_allocator: offers, commits and recycles are
// driven over valid/ready, and every result is checked against a behavioural pool model.
// Depends on apra_pkg and the address_pool_range_allocator RTL only.
module address_pool_range_allocator_test;

    localparam int HANG_LIMIT    = 20000;
    localparam int SETTLE_CYCLES = 600;
    localparam int POOL_RANGES   = 8;
    localparam int POOL_SPAN     = 256;

    typedef struct packed {
        logic [31:0] offered;
        logic        accepted;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = 2'b00;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = 2'b00;
    logic [31:0] s_now_time = 32'd0;
    logic [31:0] s_address = 32'd0;
    logic [2:0]  s_range_index = 3'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_offered_address;
    logic        m_accepted;

    // Model of the pool: registers and state.
    logic [31:0] mdl_base = 32'd0;
    logic [31:0] mdl_lease = 32'd3600;
    logic [8:0]  mdl_rlen = 9'd256;
    logic [3:0]  mdl_rcount = 4'd8;
    bit          used_map [POOL_RANGES][POOL_SPAN];
    logic [31:0] expiry_time [POOL_RANGES];
    int unsigned cur_rng;
    int unsigned cursor;

    reply_t      awaited_replies [$];
    logic [31:0] last_offer = 32'd0;
    logic [31:0] sim_now = 32'd1;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          mismatch_count = 0;
    int          n_items = 0;
    int          n_checked = 0;
    int          n_granted = 0;
    int          n_taken = 0;
    int          n_settings = 0;
    int          quiet_cycles = 0;

    address_pool_range_allocator uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_now_time        (s_now_time),
        .s_address         (s_address),
        .s_range_index     (s_range_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_offered_address (m_offered_address),
        .m_accepted        (m_accepted)
    );

    always #5 aclk = ~aclk;

    // Lengths outside the legal range are clamped.
    function automatic int unsigned eff_len();
        if (mdl_rlen == 0) return 1;
        if (mdl_rlen > POOL_SPAN) return POOL_SPAN;
        return 32'(mdl_rlen);
    endfunction

    function automatic int unsigned eff_cnt();
        if (mdl_rcount == 0) return 1;
        if (mdl_rcount > POOL_RANGES) return POOL_RANGES;
        return 32'(mdl_rcount);
    endfunction

    // First address of the current range, modulo 2^32.
    function automatic logic [31:0] current_base();
        return mdl_base + cur_rng * eff_len();
    endfunction

    function automatic void clear_pool_range(int unsigned r);
        for (int i = 0; i < POOL_SPAN; i++) used_map[r % POOL_RANGES][i] = 1'b0;
        expiry_time[r % POOL_RANGES] = 32'd0;
    endfunction

    // Computes the result of one item and advances the model state.
    function automatic reply_t pool_outcome(apra_pkg::op_t op, logic [31:0] now,
                                            logic [31:0] addr, logic [2:0] ridx);
        reply_t      res;
        int unsigned len;
        int unsigned nxt;
        logic [31:0] cand;
        logic [31:0] off;
        bit          found;
        res = '0;
        len = eff_len();
        case (op)
            apra_pkg::OP_OFFER: begin
                found = 1'b0;
                cand = 32'd0;
                // A worn-out cursor moves to the next range if it is free or has expired.
                if (cursor >= len) begin
                    nxt = (cur_rng + 1) % eff_cnt();
                    if (expiry_time[nxt] != 0 && expiry_time[nxt] <= now)
                        clear_pool_range(nxt);
                    if (expiry_time[nxt] != 0) return res;
                    cur_rng = nxt;
                    cursor = 0;
                end
                while (cursor < len && !found) begin
                    if (!used_map[cur_rng][cursor]) begin
                        found = 1'b1;
                        cand = current_base() + cursor;
                    end
                    cursor++;
                end
                // Address zero doubles as the none-free answer and sets no expiry.
                if (found && cand != 0) begin
                    if (expiry_time[cur_rng] == 0 && cursor >= len)
                        expiry_time[cur_rng] = now + mdl_lease;
                    res.offered = cand;
                end
            end
            apra_pkg::OP_COMMIT: begin
                off = addr - current_base();
                if (off < len && !used_map[cur_rng][off]) begin
                    used_map[cur_rng][off] = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            apra_pkg::OP_RECYCLE: begin
                if (ridx < eff_cnt()) clear_pool_range(ridx);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Random back-pressure on the result channel.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Result checker.
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                $display("%0t: unexpected result, expected none, got offered_address %h accepted %b",
                         $time, m_offered_address, m_accepted);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                n_checked++;
                if (m_offered_address !== want.offered) begin
                    $display("%0t: offered_address expected %h, got %h",
                             $time, want.offered, m_offered_address);
                    mismatch_count++;
                end
                if (m_accepted !== want.accepted) begin
                    $display("%0t: accepted expected %b, got %b",
                             $time, want.accepted, m_accepted);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on handshake activity.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Sends one item, with an optional idle gap first, and records its expected result.
    task automatic present_request(input apra_pkg::op_t op, input logic [31:0] now,
                                   input logic [31:0] addr, input logic [2:0] ridx);
        reply_t res;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_now_time <= now;
        s_address <= addr;
        s_range_index <= ridx;
        do @(posedge aclk); while (!s_ready);
        res = pool_outcome(op, now, addr, ridx);
        awaited_replies.push_back(res);
        n_items++;
        if (op == apra_pkg::OP_OFFER) last_offer = res.offered;
        if (res.offered != 0) n_granted++;
        if (res.accepted) n_taken++;
    endtask

    // Lets every outstanding result drain so the block is idle.
    task automatic wait_pool_idle();
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_register(input apra_pkg::cfg_reg_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        case (idx)
            apra_pkg::CFG_POOL_BASE:    mdl_base = value;
            apra_pkg::CFG_LEASE_LENGTH: mdl_lease = value;
            apra_pkg::CFG_RANGE_LENGTH: mdl_rlen = value[8:0];
            apra_pkg::CFG_RANGE_COUNT:  mdl_rcount = value[3:0];
            default: ;
        endcase
    endtask

    task automatic load_pool_settings(input logic [31:0] base, input logic [31:0] lease,
                                      input logic [8:0] rlen, input logic [3:0] rcount);
        write_register(apra_pkg::CFG_POOL_BASE, base);
        write_register(apra_pkg::CFG_LEASE_LENGTH, lease);
        write_register(apra_pkg::CFG_RANGE_LENGTH, {23'd0, rlen});
        write_register(apra_pkg::CFG_RANGE_COUNT, {28'd0, rcount});
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Reset settings: address zero, range boundaries, double commits, idle and recycle codes.
    task automatic test_default_pool();
        present_request(apra_pkg::OP_OFFER, 32'd0, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        present_request(apra_pkg::OP_COMMIT, 32'd0, 32'd1, 3'd0);
        present_request(apra_pkg::OP_COMMIT, 32'd0, 32'd1, 3'd0);
        present_request(apra_pkg::OP_COMMIT, 32'd0, 32'd0, 3'd0);
        present_request(apra_pkg::OP_COMMIT, 32'd0, 32'hFFFF_FFFF, 3'd0);
        present_request(apra_pkg::OP_COMMIT, 32'd0, 32'd256, 3'd0);
        present_request(apra_pkg::OP_COMMIT, 32'd0, 32'd255, 3'd0);
        present_request(apra_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
        present_request(apra_pkg::OP_RECYCLE, 32'd0, 32'd0, 3'd7);
        present_request(apra_pkg::OP_RECYCLE, 32'd0, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd5, 32'd0, 3'd0);
    endtask

    // Tiny ranges near the top of the address space: a cursor left past the end,
    // a base that wraps to zero, an expiry that wraps to zero, blocking and expiry.
    task automatic test_range_turnover();
        wait_pool_idle();
        load_pool_settings(32'hFFFF_FFFE, 32'd1, 9'd2, 4'd2);
        present_request(apra_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd10, 32'd0, 3'd0);
        present_request(apra_pkg::OP_COMMIT, 32'd10, 32'hFFFF_FFFE, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd10, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd10, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd10, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd10, 32'd0, 3'd0);
        present_request(apra_pkg::OP_OFFER, 32'd11, 32'd0, 3'd0);
        present_request(apra_pkg::OP_RECYCLE, 32'd0, 32'd0, 3'd2);
        present_request(apra_pkg::OP_RECYCLE, 32'd0, 32'd0, 3'd1);
    endtask

    // Phases of random traffic, each under its own settings and idling pattern.
    // Most items are offers followed by a commit of the address offered.
    task automatic test_random_traffic();
        int          phase;
        int          sent;
        int          roll;
        logic [31:0] b;
        logic [31:0] l;
        logic [8:0]  n;
        logic [3:0]  c;
        for (phase = 0; phase < 16; phase++) begin
            wait_pool_idle();
            case (phase)
                0: load_pool_settings(32'd0, 32'd0, 9'd1, 4'd1);
                1: load_pool_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd256, 4'd8);
                2: load_pool_settings(32'hFFFF_FFF0, 32'd5, 9'd0, 4'd0);
                3: load_pool_settings($urandom, 32'd3, 9'd511, 4'd15);
                default: begin
                    case ($urandom_range(3))
                        0: b = 32'd0;
                        1: b = 32'hFFFF_FFFF - $urandom_range(40);
                        2: b = $urandom;
                        default: b = $urandom_range(1, 1000);
                    endcase
                    case ($urandom_range(3))
                        0: l = 32'd0;
                        1: l = $urandom_range(1, 20);
                        2: l = $urandom_range(20, 400);
                        default: l = $urandom;
                    endcase
                    if ($urandom_range(9) == 0) begin
                        case ($urandom_range(3))
                            0: n = 9'd0;
                            1: n = 9'd256;
                            2: n = 9'($urandom_range(257, 511));
                            default: n = 9'($urandom_range(17, 255));
                        endcase
                    end else begin
                        n = 9'($urandom_range(1, 16));
                    end
                    c = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(1, 8));
                    load_pool_settings(b, l, n, c);
                end
            endcase
            send_idle_pct = (phase % 4 == 1) ? 48 : (phase % 4 == 3) ? 16 : 0;
            stall_pct = (phase % 4 == 2) ? 48 : (phase % 4 == 3) ? 16 : 0;
            sent = 0;
            while (sent < 100) begin
                roll = $urandom_range(99);
                if (roll < 50) begin
                    present_request(apra_pkg::OP_OFFER, sim_now, $urandom,
                                    3'($urandom_range(7)));
                    sent++;
                    sim_now = sim_now + $urandom_range(4);
                    if ($urandom_range(49) == 0) sim_now = sim_now + $urandom_range(2000);
                    if (last_offer != 0 && $urandom_range(99) < 80) begin
                        present_request(apra_pkg::OP_COMMIT, $urandom, last_offer,
                                        3'($urandom_range(7)));
                        sent++;
                    end
                end else if (roll < 58) begin
                    present_request(apra_pkg::OP_OFFER, $urandom, $urandom,
                                    3'($urandom_range(7)));
                    sent++;
                end else if (roll < 70) begin
                    present_request(apra_pkg::OP_COMMIT, $urandom,
                                    current_base() + $urandom_range(eff_len() + 1),
                                    3'($urandom_range(7)));
                    sent++;
                end else if (roll < 78) begin
                    present_request(apra_pkg::OP_COMMIT, $urandom, $urandom,
                                    3'($urandom_range(7)));
                    sent++;
                end else if (roll < 88) begin
                    present_request(apra_pkg::OP_RECYCLE, $urandom, $urandom,
                                    3'($urandom_range(7)));
                    sent++;
                end else if (roll < 93) begin
                    // These still yield a result from the block, but they do not count towards the phase.
                    present_request(apra_pkg::OP_NONE, $urandom, $urandom,
                                    3'($urandom_range(7)));
                end else begin
                    // A repeated commit of the last address offered, which may already be taken.
                    present_request(apra_pkg::OP_COMMIT, $urandom, last_offer,
                                    3'($urandom_range(7)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        for (int r = 0; r < POOL_RANGES; r++) clear_pool_range(r);
        cur_rng = 0;
        cursor = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_pool();
        test_range_turnover();
        test_random_traffic();
        s_valid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d items under %0d register settings, %0d results checked.",
                 n_items, n_settings + 1, n_checked);
        $display("Addresses offered: %0d, commits taken: %0d.", n_granted, n_taken);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
